### rtl/extended_timer_time_scaler_assert.svh
// Assertion macros for the extended timer time scaler.
// Included by files that check their own sequencing; no other dependencies.
`ifndef EXTENDED_TIMER_TIME_SCALER_ASSERT_SVH
`define EXTENDED_TIMER_TIME_SCALER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset
`define ETS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled in reset
`define ETS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ETS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ETS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/ets_pkg.sv
// Shared types and constants for the extended timer time scaler.
// No dependencies; every other file but the assertion header imports this package.
`default_nettype none

package ets_pkg;

    // Field and port widths
    localparam int unsigned OP_W       = 3;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned SHIFT_W    = 3;
    localparam int unsigned MHZ_W      = 8;
    localparam int unsigned FACTOR_W   = 15;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned PRE_W      = 7;

    // Shared multiplier and divider widths
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 15;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int unsigned PROD_W  = WORD_W + FACTOR_W;
    localparam int unsigned DIV_N_W = 32;
    localparam int unsigned DIV_D_W = 8;
    localparam int unsigned DIV_C_W = $clog2(DIV_N_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_SHIFT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_FREQ_MHZ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_US_FACTOR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MS_FACTOR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_S_FACTOR       = 3'd4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
    localparam logic [OP_W-1:0] OP_READ_TICKS  = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_US     = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_MS     = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_S      = 3'd4;
    localparam logic [OP_W-1:0] OP_TICKS_TO_US = 3'd5;
    localparam logic [OP_W-1:0] OP_US_TO_TICKS = 3'd6;

    // Reset values of the configuration registers
    localparam logic [SHIFT_W-1:0]  RST_PRESCALE_SHIFT = 3'd0;
    localparam logic [MHZ_W-1:0]    RST_CPU_FREQ_MHZ   = 8'd16;
    localparam logic [FACTOR_W-1:0] RST_US_FACTOR      = 15'd128;
    localparam logic [FACTOR_W-1:0] RST_MS_FACTOR      = 15'd131;
    localparam logic [FACTOR_W-1:0] RST_S_FACTOR       = 15'd134;

    // Scaling constants
    localparam logic [DATA_W-1:0] ALL_ONES32  = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] MS_LOW_MASK = 16'h001F;
    localparam logic [WORD_W-1:0] S_LOW_MASK  = 16'h7FFF;
    localparam logic [32:0]       US_ROUND    = 33'h0_0000_0400;
    localparam logic [32:0]       MS_ROUND    = 33'h0_0010_0000;
    localparam logic [32:0]       S_ROUND     = 33'h0_4000_0000;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

    // The three counter words
    typedef struct packed {
        logic [WORD_W-1:0] tick;
        logic [WORD_W-1:0] ovf;
        logic [WORD_W-1:0] wrap;
    } t_time_words;

endpackage

`default_nettype wire

### rtl/ets_in_if.sv
// Input channel of the time scaler: valid, ready, operation and operand.
// Depends on ets_pkg for the field widths.
`default_nettype none

interface ets_in_if import ets_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] operand;

    modport source (output valid, output operation, output operand, input ready);
    modport sink   (input valid, input operation, input operand, output ready);
endinterface

`default_nettype wire

### rtl/ets_out_if.sv
// Result channel of the time scaler: valid, ready and value.
// Depends on ets_pkg for the field width.
`default_nettype none

interface ets_out_if import ets_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### rtl/ets_timer.sv
// Prescaler and 48-bit tick counter kept as three 16-bit words.
// Depends on ets_pkg.
`default_nettype none

module ets_timer import ets_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic [SHIFT_W-1:0] i_shift,
    output t_time_words        o_words
);

    logic [PRE_W-1:0]  r_pre,  n_pre;
    logic [WORD_W-1:0] r_tick, n_tick;
    logic [WORD_W-1:0] r_ovf,  n_ovf;
    logic [WORD_W-1:0] r_wrap, n_wrap;
    logic [PRE_W:0]    w_span;
    logic [PRE_W-1:0]  w_limit;

    // Prescaler terminal count is 2^shift - 1
    assign w_span  = (PRE_W+1)'(1) << i_shift;
    assign w_limit = w_span[PRE_W-1:0] - PRE_W'(1);

    // Advance prescaler, then the counter words on carry
    always_comb begin
        n_pre  = r_pre;
        n_tick = r_tick;
        n_ovf  = r_ovf;
        n_wrap = r_wrap;
        if (i_tick) begin
            if (r_pre >= w_limit) begin
                n_pre  = '0;
                n_tick = r_tick + WORD_W'(1);
                if (r_tick == '1) begin
                    n_ovf = r_ovf + WORD_W'(1);
                    if (r_ovf == '1) begin
                        n_wrap = r_wrap + WORD_W'(1);
                    end
                end
            end else begin
                n_pre = r_pre + PRE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre  <= '0;
            r_tick <= '0;
            r_ovf  <= '0;
            r_wrap <= '0;
        end else begin
            r_pre  <= n_pre;
            r_tick <= n_tick;
            r_ovf  <= n_ovf;
            r_wrap <= n_wrap;
        end
    end

    assign o_words.tick = r_tick;
    assign o_words.ovf  = r_ovf;
    assign o_words.wrap = r_wrap;

endmodule

`default_nettype wire

### rtl/ets_mul.sv
// Shared registered multiplier, 32 by 15 bits, for time reads and scaling.
// Depends on ets_pkg.
`default_nettype none

module ets_mul import ets_pkg::*; (
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_p;

    // Register the product every cycle
    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

### rtl/ets_div.sv
// Restoring divider, 32-bit dividend by 8-bit divisor, one quotient bit a cycle.
// Depends on ets_pkg for the request and response structs.
`default_nettype none

module ets_div import ets_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [DIV_C_W-1:0] LAST_STEP = DIV_C_W'(DIV_N_W - 1);

    logic [DIV_N_W-1:0] r_quo,  n_quo;
    logic [DIV_D_W-1:0] r_rem,  n_rem;
    logic [DIV_D_W-1:0] r_den,  n_den;
    logic [DIV_C_W-1:0] r_cnt,  n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DIV_D_W:0]   w_trial;
    logic [DIV_D_W:0]   w_diff;

    // Trial subtract of the divisor from the shifted partial remainder
    assign w_trial = {r_rem, r_quo[DIV_N_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_den  = i_req.divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // Keep the difference when no borrow, else restore
            if (!w_diff[DIV_D_W]) begin
                n_rem = w_diff[DIV_D_W-1:0];
                n_quo = {r_quo[DIV_N_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DIV_D_W-1:0];
                n_quo = {r_quo[DIV_N_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + DIV_C_W'(1);
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

### rtl/extended_timer_time_scaler.sv
// Top level of the extended timer time scaler: sequencer, configuration,
// output register. Depends on ets_pkg, ets_in_if, ets_out_if, ets_timer,
// ets_mul, ets_div and extended_timer_time_scaler_assert.svh.
//
//   channel   direction  handshake          payload
//   i_in      sink       valid / ready      operation[2:0], operand[31:0]
//   o_out     source     valid / ready      value[31:0]
//   i_cfg_*   write      i_cfg_we           i_cfg_index[2:0], i_cfg_data[14:0]
//
// Time reads make three passes through the shared multiplier; ticks to us
// uses the 32-step divider, and us to ticks the divider plus one multiplier
// pass. Reset is synchronous; counters clear, registers load their defaults.
// One finished result waits in the output register; while it is not taken a
// further result holds in the done state and input ready stays low.
`default_nettype none

`include "extended_timer_time_scaler_assert.svh"

module extended_timer_time_scaler import ets_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ets_in_if.sink                i_in,
    ets_out_if.source             o_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_DIV  = 5'b00100,
        S_MULX = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op,    n_op;
    logic [DATA_W-1:0]   r_x,     n_x;
    logic [1:0]          r_step,  n_step;
    logic [PROD_W-1:0]   r_pl,    n_pl;
    logic [PROD_W-1:0]   r_pm,    n_pm;
    logic [DATA_W-1:0]   r_res,   n_res;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_value, n_out_value;

    logic [SHIFT_W-1:0]  r_shift;
    logic [MHZ_W-1:0]    r_mhz;
    logic [FACTOR_W-1:0] r_us_factor;
    logic [FACTOR_W-1:0] r_ms_factor;
    logic [FACTOR_W-1:0] r_s_factor;

    logic                w_in_acc;
    logic                w_tick;
    logic                w_mhz_zero;
    t_time_words         w_words;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;
    logic [MUL_A_W-1:0]  w_mul_a;
    logic [MUL_B_W-1:0]  w_mul_b;
    logic [MUL_P_W-1:0]  w_mul_p;
    logic [WORD_W-1:0]   w_word;
    logic [FACTOR_W-1:0] w_factor;
    logic [DATA_W-1:0]   w_max_ticks;
    logic [DATA_W-1:0]   w_x5;
    logic [DATA_W-1:0]   w_num;
    logic [PROD_W-1:0]   w_ph;
    logic [32:0]         w_round;
    logic [WORD_W-1:0]   w_mask;
    logic [32:0]         w_low;
    logic [WORD_W-1:0]   w_read;
    logic [DATA_W-1:0]   w_scaled;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_tick      = w_in_acc && (i_in.operation == OP_TICK);
    assign w_mhz_zero  = (r_mhz == '0);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= RST_PRESCALE_SHIFT;
            r_mhz       <= RST_CPU_FREQ_MHZ;
            r_us_factor <= RST_US_FACTOR;
            r_ms_factor <= RST_MS_FACTOR;
            r_s_factor  <= RST_S_FACTOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRESCALE_SHIFT: r_shift     <= i_cfg_data[SHIFT_W-1:0];
                CFG_CPU_FREQ_MHZ:   r_mhz       <= i_cfg_data[MHZ_W-1:0];
                CFG_US_FACTOR:      r_us_factor <= i_cfg_data[FACTOR_W-1:0];
                CFG_MS_FACTOR:      r_ms_factor <= i_cfg_data[FACTOR_W-1:0];
                CFG_S_FACTOR:       r_s_factor  <= i_cfg_data[FACTOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ets_timer u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_tick),
        .i_shift (r_shift),
        .o_words (w_words)
    );

    ets_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    ets_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Select the counter word and factor for the multiplier
    always_comb begin
        case (r_step)
            2'd0:    w_word = w_words.tick;
            2'd1:    w_word = w_words.ovf;
            default: w_word = w_words.wrap;
        endcase
        case (r_op)
            OP_READ_US: w_factor = r_us_factor;
            OP_READ_MS: w_factor = r_ms_factor;
            default:    w_factor = r_s_factor;
        endcase
        if (r_state == S_MULX) begin
            w_mul_a = r_x;
            w_mul_b = MUL_B_W'(r_mhz);
        end else begin
            w_mul_a = MUL_A_W'(w_word);
            w_mul_b = w_factor;
        end
    end

    // Saturate ticks and scale by the prescaler for ticks to us
    assign w_max_ticks = ALL_ONES32 >> r_shift;
    assign w_x5        = (i_in.operand > w_max_ticks) ? w_max_ticks : i_in.operand;
    assign w_num       = w_x5 << r_shift;

    // Start the divider for both conversions unless the MHz register is zero
    always_comb begin
        w_div_req.start    = w_in_acc && !w_mhz_zero &&
                             ((i_in.operation == OP_TICKS_TO_US) ||
                              (i_in.operation == OP_US_TO_TICKS));
        w_div_req.dividend = (i_in.operation == OP_TICKS_TO_US) ? w_num : ALL_ONES32;
        w_div_req.divisor  = r_mhz;
    end

    // Combine the three partial products into a 16-bit time reading
    assign w_ph = w_mul_p[PROD_W-1:0];
    always_comb begin
        case (r_op)
            OP_READ_US: begin
                w_round = US_ROUND;
                w_mask  = '0;
            end
            OP_READ_MS: begin
                w_round = MS_ROUND;
                w_mask  = MS_LOW_MASK;
            end
            default: begin
                w_round = S_ROUND;
                w_mask  = S_LOW_MASK;
            end
        endcase
        w_low = {2'b00, r_pl} + w_round + {1'b0, r_pm[WORD_W-1:0] & w_mask, 16'h0000};
        case (r_op)
            OP_READ_US: w_read = w_low[26:11] + {r_pm[10:0], 5'b00000};
            OP_READ_MS: w_read = {4'h0, w_low[32:21]} + r_pm[20:5] + {w_ph[4:0], 11'h000};
            default:    w_read = {14'h0000, w_low[32:31]} + r_pm[30:15] + {w_ph[14:0], 1'b0};
        endcase
    end

    assign w_scaled = w_mul_p[DATA_W-1:0] >> r_shift;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_x         = r_x;
        n_step      = r_step;
        n_pl        = r_pl;
        n_pm        = r_pm;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_value = r_out_value;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op   = i_in.operation;
                    n_x    = i_in.operand;
                    n_step = '0;
                    case (i_in.operation)
                        OP_READ_TICKS: begin
                            n_res   = {w_words.ovf, w_words.tick};
                            n_state = S_DONE;
                        end
                        OP_READ_US, OP_READ_MS, OP_READ_S: begin
                            n_state = S_READ;
                        end
                        OP_TICKS_TO_US: begin
                            if (w_mhz_zero) begin
                                n_res   = ALL_ONES32;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                        OP_US_TO_TICKS: begin
                            if (w_mhz_zero) begin
                                n_res   = '0;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // Issue one word a cycle, capture each product in the cycle after its word
                n_step = r_step + 2'd1;
                case (r_step)
                    2'd1: n_pl = w_mul_p[PROD_W-1:0];
                    2'd2: n_pm = w_mul_p[PROD_W-1:0];
                    2'd3: begin
                        n_res   = DATA_W'(w_read);
                        n_state = S_DONE;
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    if (r_op == OP_TICKS_TO_US) begin
                        n_res   = w_div_rsp.quotient;
                        n_state = S_DONE;
                    end else begin
                        // Clamp microseconds to all-ones over MHz
                        if (r_x > w_div_rsp.quotient) begin
                            n_x = w_div_rsp.quotient;
                        end
                        n_step  = '0;
                        n_state = S_MULX;
                    end
                end
            end
            S_MULX: begin
                n_step = r_step + 2'd1;
                if (r_step != '0) begin
                    n_res   = w_scaled;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand over once the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_x         <= n_x;
        r_pl        <= n_pl;
        r_pm        <= n_pm;
        r_res       <= n_res;
        r_out_value <= n_out_value;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;

    // Divider finishes only while the sequencer waits for it
    `ETS_ASSERT_IMPL(a_div_done_in_div, i_clk, i_rst_n, w_div_rsp.done, r_state == S_DIV)
    // A bus-clock tick never leaves the idle state
    `ETS_ASSERT_NEXT(a_tick_stays_idle, i_clk, i_rst_n, w_tick, r_state == S_IDLE)
    // A new result enters the output register only from the done state
    `ETS_ASSERT_IMPL(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE)

endmodule

`default_nettype wire
